// ===== design/greedy_solid_rect_merge_top_assert.svh =====
// Assertion macros for the rectangle merge block.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef GREEDY_SOLID_RECT_MERGE_TOP_ASSERT_SVH
`define GREEDY_SOLID_RECT_MERGE_TOP_ASSERT_SVH

// Same-cycle implication
`define GSRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gsrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrm_pkg
// Shared types and constants of the greedy solid rectangle merge block.
// ----------------------------------------------------------------------------
package gsrm_pkg;

  localparam int ROW_W       = 8;   // solid flags per row
  localparam int XW          = $clog2(ROW_W);
  localparam int WW          = $clog2(ROW_W + 1);
  localparam int CELL_W      = 5;   // cell coordinates and extents, grid up to 31
  localparam int BP_W        = 8;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int POS_W       = 21;
  localparam int EXT_W       = 11;
  localparam int PROD_W      = CELL_W + BP_W;
  localparam int EXTENT_MAX  = 2047;
  localparam int MAX_RESULTS = 32;
  localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [BP_W-1:0] BP_RESET = BP_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_PIXELS = 2'd0,
    CFG_ORIGIN_X     = 2'd1,
    CFG_ORIGIN_Y     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controls broadcast from the scan controller to every row lane
  typedef struct packed {
    logic              load;
    logic [CELL_W-1:0] load_row;
    logic [ROW_W-1:0]  wdata;
    logic              clear;
    logic              mark;
    logic [ROW_W-1:0]  run;
    logic [CELL_W-1:0] top;
    logic [CELL_W-1:0] stop;
  } lane_ctl_t;

  // One rectangle in cell units on its way to the pixel stage
  typedef struct packed {
    logic              strobe;
    logic              rect_valid;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] w;
    logic [CELL_W-1:0] h;
    logic              last;
  } emit_t;

endpackage

// ===== design/gsrm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrm_lane
// One grid row: holds its solid and visited flags, reports free cells and
// whether the current run fits, and marks the run visited when covered.
// ----------------------------------------------------------------------------
module gsrm_lane
  import gsrm_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic             clk,
  input  lane_ctl_t        lane_ctl_i,
  output logic [ROW_W-1:0] free_row_o,
  output logic             fits_o
);

  logic [ROW_W-1:0] solid_r;
  logic [ROW_W-1:0] visited_r;
  logic             hit;

  // Row lies inside the rectangle being placed
  assign hit = (CELL_W'(LANE) >= lane_ctl_i.top) && (CELL_W'(LANE) < lane_ctl_i.stop);

  assign free_row_o = solid_r & ~visited_r;
  assign fits_o     = ((free_row_o & lane_ctl_i.run) == lane_ctl_i.run);

  // Load the row on its transfer
  always_ff @(posedge clk) begin
    if (lane_ctl_i.load && (lane_ctl_i.load_row == CELL_W'(LANE))) begin
      solid_r <= lane_ctl_i.wdata;
    end
  end

  // Clear per grid, mark covered cells
  always_ff @(posedge clk) begin
    if (lane_ctl_i.clear) begin
      visited_r <= '0;
    end else if (lane_ctl_i.mark && hit) begin
      visited_r <= visited_r | lane_ctl_i.run;
    end
  end

endmodule

// ===== design/gsrm_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrm_scan
// Row loader and scan controller: finds the next free run in the current
// row, merges the lane fit flags into a height, and issues rectangles.
// ----------------------------------------------------------------------------
module gsrm_scan
  import gsrm_pkg::*;
#(
  parameter int GRID_SIDE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ROW_W-1:0]     row_mask_i,
  input  logic [ROW_W-1:0]     free_rows_i [GRID_SIDE],
  input  logic [GRID_SIDE-1:0] fits_i,
  output logic                 busy_o,
  output lane_ctl_t            lane_ctl_o,
  output emit_t                emit_o
);

  localparam int YW   = $clog2(GRID_SIDE);
  localparam int HW   = $clog2(GRID_SIDE + 1);
  localparam int COLS = (GRID_SIDE < ROW_W) ? GRID_SIDE : ROW_W;
  localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((1 << COLS) - 1);

  state_t             state_r, state_nxt;
  logic [YW-1:0]      load_cnt_r, load_cnt_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  emit_t              pend_r, pend_nxt;

  logic [ROW_W-1:0]   free;
  logic [ROW_W-1:0]   low;
  logic [ROW_W:0]     carry_sum;
  logic [ROW_W-1:0]   run;
  logic [XW-1:0]      cell_x;
  logic [WW-1:0]      cell_w;
  logic [YW:0]        shamt;
  logic [GRID_SIDE:0] below;
  logic [GRID_SIDE:0] gap;
  logic [GRID_SIDE:0] gap_low;
  logic [HW-1:0]      ones;
  logic [HW-1:0]      cell_h;

  // Find the first free run of the current row and its height
  always_comb begin
    free      = free_rows_i[y_r];
    low       = free & (~free + ROW_W'(1));
    carry_sum = {1'b0, free} + {1'b0, low};
    run       = free & ~carry_sum[ROW_W-1:0];
    cell_x    = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (low[i]) begin
        cell_x = cell_x | XW'(i);
      end
    end
    cell_w  = WW'($countones(run));
    shamt   = {1'b0, y_r} + (YW+1)'(1);
    below   = {1'b0, fits_i} >> shamt;
    gap     = ~below;
    gap_low = gap & (~gap + (GRID_SIDE+1)'(1));
    ones    = '0;
    for (int i = 0; i <= GRID_SIDE; i++) begin
      if (gap_low[i]) begin
        ones = ones | HW'(i);
      end
    end
    cell_h = ones + HW'(1);
  end

  // Next state, lane controls and rectangle issue
  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    y_nxt          = y_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    busy_o         = 1'b1;
    emit_o         = '0;

    lane_ctl_o          = '0;
    lane_ctl_o.load_row = CELL_W'(load_cnt_r);
    lane_ctl_o.wdata    = row_mask_i & COL_MASK;
    lane_ctl_o.run      = run;
    lane_ctl_o.top      = CELL_W'(y_r);
    lane_ctl_o.stop     = CELL_W'(y_r) + CELL_W'(cell_h);

    unique case (state_r)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start) begin
          lane_ctl_o.load = 1'b1;
          if (load_cnt_r == YW'(GRID_SIDE - 1)) begin
            load_cnt_nxt     = '0;
            lane_ctl_o.clear = 1'b1;
            y_nxt            = '0;
            found_nxt        = '0;
            pend_valid_nxt   = 1'b0;
            state_nxt        = ST_SCAN;
          end else begin
            load_cnt_nxt = load_cnt_r + YW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (free == '0) begin
          // Row fully covered: advance or finish
          if (y_r == YW'(GRID_SIDE - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            y_nxt = y_r + YW'(1);
          end
        end else begin
          lane_ctl_o.mark = 1'b1;
          if (pend_valid_r && (found_r == FOUND_W'(MAX_RESULTS))) begin
            // Result limit reached: close with the held rectangle, drop the rest
            emit_o            = pend_r;
            emit_o.strobe     = 1'b1;
            emit_o.rect_valid = 1'b1;
            emit_o.last       = 1'b1;
            state_nxt         = ST_LOAD;
          end else begin
            if (pend_valid_r) begin
              emit_o            = pend_r;
              emit_o.strobe     = 1'b1;
              emit_o.rect_valid = 1'b1;
              emit_o.last       = 1'b0;
            end
            pend_nxt       = '0;
            pend_nxt.x     = CELL_W'(cell_x);
            pend_nxt.y     = CELL_W'(y_r);
            pend_nxt.w     = CELL_W'(cell_w);
            pend_nxt.h     = CELL_W'(cell_h);
            pend_valid_nxt = 1'b1;
            found_nxt      = found_r + FOUND_W'(1);
          end
        end
      end
      ST_DONE: begin
        // Close the grid; an empty grid gives one invalid item
        emit_o.strobe = 1'b1;
        emit_o.last   = 1'b1;
        if (pend_valid_r) begin
          emit_o.rect_valid = 1'b1;
          emit_o.x          = pend_r.x;
          emit_o.y          = pend_r.y;
          emit_o.w          = pend_r.w;
          emit_o.h          = pend_r.h;
        end
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_cnt_r   <= '0;
      y_r          <= '0;
      found_r      <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_cnt_r   <= load_cnt_nxt;
      y_r          <= y_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Held rectangle
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

// ===== design/gsrm_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrm_out
// Configuration registers and the pixel stage: scales cell rectangles by
// the block size, adds the origin, saturates extents and registers results.
// ----------------------------------------------------------------------------
module gsrm_out
  import gsrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  emit_t                emit_i,
  output logic                 out_strobe,
  output logic                 out_rect_valid,
  output logic [POS_W-1:0]     out_rect_x,
  output logic [POS_W-1:0]     out_rect_y,
  output logic [EXT_W-1:0]     out_rect_width,
  output logic [EXT_W-1:0]     out_rect_height,
  output logic                 out_last_rect
);

  logic [BP_W-1:0]   blk_r;
  logic [CFG_W-1:0]  org_x_r;
  logic [CFG_W-1:0]  org_y_r;

  logic              strobe_r;
  logic              valid_r, last_r;
  logic [POS_W-1:0]  x_r, x_nxt;
  logic [POS_W-1:0]  y_r, y_nxt;
  logic [EXT_W-1:0]  w_r, w_nxt;
  logic [EXT_W-1:0]  h_r, h_nxt;

  logic [PROD_W-1:0] prod_x, prod_y, prod_w, prod_h;

  function automatic logic [EXT_W-1:0] ext_sat(input logic [PROD_W-1:0] p);
    ext_sat = (p > PROD_W'(EXTENT_MAX)) ? EXT_W'(EXTENT_MAX) : p[EXT_W-1:0];
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r   <= BP_RESET;
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_PIXELS: blk_r   <= cfg_wdata[BP_W-1:0];
        CFG_ORIGIN_X:     org_x_r <= cfg_wdata;
        CFG_ORIGIN_Y:     org_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scale to pixels; an invalid item carries all zero fields
  always_comb begin
    prod_x = PROD_W'(emit_i.x) * PROD_W'(blk_r);
    prod_y = PROD_W'(emit_i.y) * PROD_W'(blk_r);
    prod_w = PROD_W'(emit_i.w) * PROD_W'(blk_r);
    prod_h = PROD_W'(emit_i.h) * PROD_W'(blk_r);
    if (emit_i.rect_valid) begin
      x_nxt = POS_W'(prod_x) + POS_W'(org_x_r);
      y_nxt = POS_W'(prod_y) + POS_W'(org_y_r);
      w_nxt = ext_sat(prod_w);
      h_nxt = ext_sat(prod_h);
    end else begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = '0;
      h_nxt = '0;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= emit_i.strobe;
    end
  end

  // Hold result payload until the next transfer
  always_ff @(posedge clk) begin
    if (emit_i.strobe) begin
      valid_r <= emit_i.rect_valid;
      last_r  <= emit_i.last;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_rect_valid  = valid_r;
  assign out_last_rect   = last_r;
  assign out_rect_x      = x_r;
  assign out_rect_y      = y_r;
  assign out_rect_width  = w_r;
  assign out_rect_height = h_r;

endmodule

// ===== design/greedy_solid_rect_merge_top.sv =====
`timescale 1ns / 1ps
// Loading: one row per cycle while busy is low; a grid of GRID_SIDE rows takes GRID_SIDE
// transfers. Scan: busy while the controller walks the rows, placing one rectangle per
// step and stepping past each fully covered row (at most 32 rectangles issued).
// Results: a result shows in the cycle after the next rectangle is found; the last
// shows in the cycle busy falls. No stalls.
// Reset (synchronous, rst_n low): load counter cleared, registers to defaults.
// ----------------------------------------------------------------------------
// greedy_solid_rect_merge_top
// Covers a square grid of solid flags with rectangles in raster order and
// reports each rectangle in pixels.
// ----------------------------------------------------------------------------
module greedy_solid_rect_merge_top
  import gsrm_pkg::*;
#(
  parameter int GRID_SIDE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ROW_W-1:0]     in_row_solid_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_strobe,
  output logic                 out_rect_valid,
  output logic [POS_W-1:0]     out_rect_x,
  output logic [POS_W-1:0]     out_rect_y,
  output logic [EXT_W-1:0]     out_rect_width,
  output logic [EXT_W-1:0]     out_rect_height,
  output logic                 out_last_rect
);

  lane_ctl_t            lane_ctl;
  emit_t                emit;
  logic [ROW_W-1:0]     free_rows [GRID_SIDE];
  logic [GRID_SIDE-1:0] fits;

  // Scan controller and merge
  gsrm_scan #(
    .GRID_SIDE (GRID_SIDE)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .row_mask_i  (in_row_solid_mask),
    .free_rows_i (free_rows),
    .fits_i      (fits),
    .busy_o      (busy),
    .lane_ctl_o  (lane_ctl),
    .emit_o      (emit)
  );

  // One lane per grid row
  for (genvar i = 0; i < GRID_SIDE; i++) begin : g_lane
    gsrm_lane #(
      .LANE (i)
    ) u_lane (
      .clk        (clk),
      .lane_ctl_i (lane_ctl),
      .free_row_o (free_rows[i]),
      .fits_o     (fits[i])
    );
  end

  // Pixel stage and configuration
  gsrm_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .emit_i          (emit),
    .out_strobe      (out_strobe),
    .out_rect_valid  (out_rect_valid),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_last_rect   (out_last_rect)
  );

endmodule

// ===== design/gsrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrm_checker
// Port-level checks of result framing against the busy flag.
// ----------------------------------------------------------------------------
`include "greedy_solid_rect_merge_top_assert.svh"

module gsrm_checker
  import gsrm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_strobe,
  input logic             out_rect_valid,
  input logic [POS_W-1:0] out_rect_x,
  input logic [POS_W-1:0] out_rect_y,
  input logic [EXT_W-1:0] out_rect_width,
  input logic [EXT_W-1:0] out_rect_height,
  input logic             out_last_rect
);

  logic empty_item;
  logic geom_zero;

  assign empty_item = out_strobe && !out_rect_valid;
  assign geom_zero  = (out_rect_x == '0) && (out_rect_y == '0) &&
                      (out_rect_width == '0) && (out_rect_height == '0);

  // An empty (invalid) item always closes the grid
  `GSRM_ASSERT_SAME(a_empty_is_last, empty_item, out_last_rect, "empty item not last")

  // The empty item carries no geometry
  `GSRM_ASSERT_SAME(a_empty_zero, empty_item, geom_zero, "empty item has nonzero fields")

  // Busy drops exactly with the closing transfer
  `GSRM_ASSERT_SAME(a_idle_with_last, $fell(busy), out_strobe && out_last_rect, "busy fell without last result")

  // More results follow a non-final one: the scan still runs or the next one is out
  `GSRM_ASSERT_NEXT(a_busy_after_mid, out_strobe && !out_last_rect, busy || out_strobe, "no result after non-final result")

endmodule

bind greedy_solid_rect_merge_top gsrm_checker u_gsrm_checker (.*);

// ===== dv/greedy_solid_rect_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_solid_rect_merge_checker
// Watches the row, register and rectangle channels of the merge block.
// Mirrors the row store and the register values, and works out the
// rectangle cover of each completed grid. Compares every rectangle, field
// by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module greedy_solid_rect_merge_checker
  import gsrm_pkg::*;
#(
  parameter int GRID_SIDE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [ROW_W-1:0]     in_row_solid_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 out_strobe,
  input  logic                 out_rect_valid,
  input  logic [POS_W-1:0]     out_rect_x,
  input  logic [POS_W-1:0]     out_rect_y,
  input  logic [EXT_W-1:0]     out_rect_width,
  input  logic [EXT_W-1:0]     out_rect_height,
  input  logic                 out_last_rect,
  output int                   fail_count,
  output int                   pending
);

  localparam int COLS = (GRID_SIDE < ROW_W) ? GRID_SIDE : ROW_W;
  localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((1 << COLS) - 1);

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [EXT_W-1:0] w;
    logic [EXT_W-1:0] h;
    logic             last;
  } rect_t;

  logic [BP_W-1:0]  blk_px;
  logic [CFG_W-1:0] org_x;
  logic [CFG_W-1:0] org_y;
  logic [ROW_W-1:0] solid_q [GRID_SIDE];
  int               rows_in;
  rect_t            rect_q [$];

  // Pixel extent of a run of cells, clipped to the port width
  function automatic logic [EXT_W-1:0] to_extent(input int cells);
    int px;
    px = cells * int'(blk_px);
    return (px > EXTENT_MAX) ? EXT_W'(EXTENT_MAX) : EXT_W'(px);
  endfunction

  // Greedy raster-order cover of the loaded grid; append its rectangles
  function automatic void merge_grid();
    logic [ROW_W-1:0] taken [GRID_SIDE];
    logic [ROW_W-1:0] open_cols;
    logic [ROW_W-1:0] run;
    rect_t            found_q [$];
    rect_t            r;
    int               w;
    int               h;
    for (int y = 0; y < GRID_SIDE; y++) taken[y] = '0;
    for (int y = 0; y < GRID_SIDE; y++) begin
      for (int x = 0; x < COLS; x++) begin
        open_cols = solid_q[y] & ~taken[y];
        if (!open_cols[x]) continue;
        // grow right, then down while the whole run stays free and solid
        w = 1;
        while (x + w < COLS && open_cols[x + w]) w++;
        run = ROW_W'(((1 << w) - 1) << x);
        h = 1;
        while (y + h < GRID_SIDE && ((solid_q[y + h] & ~taken[y + h] & run) == run)) h++;
        for (int j = 0; j < h; j++) taken[y + j] = taken[y + j] | run;
        // drop rectangles past the result cap
        if (found_q.size() < MAX_RESULTS) begin
          r.valid = 1'b1;
          r.x     = POS_W'(x * int'(blk_px) + int'(org_x));
          r.y     = POS_W'(y * int'(blk_px) + int'(org_y));
          r.w     = to_extent(w);
          r.h     = to_extent(h);
          r.last  = 1'b0;
          found_q.push_back(r);
        end
      end
    end
    // an empty grid still reports one marker item
    if (found_q.size() == 0) begin
      r = '0;
      found_q.push_back(r);
    end
    r = found_q.pop_back();
    r.last = 1'b1;
    found_q.push_back(r);
    foreach (found_q[i]) rect_q.push_back(found_q[i]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endfunction

  // Track registers and rows, compare each result transfer
  always @(posedge clk) begin : watch
    rect_t want;
    if (!rst_n) begin
      blk_px  = BP_RESET;
      org_x   = '0;
      org_y   = '0;
      rows_in = 0;
      rect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_PIXELS: blk_px = cfg_wdata[BP_W-1:0];
          CFG_ORIGIN_X:     org_x  = cfg_wdata;
          CFG_ORIGIN_Y:     org_y  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (rect_q.size() == 0) begin
          $display("%0t: unexpected rectangle, expected none, actual x=%0d y=%0d w=%0d h=%0d",
                   $realtime, out_rect_x, out_rect_y, out_rect_width, out_rect_height);
          fail_count++;
        end else begin
          want = rect_q.pop_front();
          check_field("rect_valid", int'(want.valid), int'(out_rect_valid));
          check_field("rect_x", int'(want.x), int'(out_rect_x));
          check_field("rect_y", int'(want.y), int'(out_rect_y));
          check_field("rect_width", int'(want.w), int'(out_rect_width));
          check_field("rect_height", int'(want.h), int'(out_rect_height));
          check_field("last_rect", int'(want.last), int'(out_last_rect));
        end
      end
      if (start && !busy) begin
        solid_q[rows_in] = in_row_solid_mask & COL_MASK;
        rows_in++;
        if (rows_in == GRID_SIDE) begin
          rows_in = 0;
          merge_grid();
        end
      end
    end
    pending = rect_q.size();
  end

endmodule

// ===== dv/greedy_solid_rect_merge_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_solid_rect_merge_top_tb
// Feeds whole grids of row masks to the merge block under a series of
// register settings: directed grids first (empty, full, checkerboard with
// the most rectangles), then random grids of mixed density. Random gaps on
// the row channel; the checker beside the block gives the failure count.
// ----------------------------------------------------------------------------
module greedy_solid_rect_merge_top_tb;
  import gsrm_pkg::*;

  localparam int GRID_SIDE       = 8;
  localparam int GRIDS_PER_PHASE = 4;
  localparam int RANDOM_PHASES   = 9;
  localparam int MAX_GAP         = 4;
  localparam int SETTLE_CYCLES   = 16;
  localparam int QUIET_LIMIT     = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [CFG_W-1:0]     ORIGIN_TOP    = '1;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_DENSE,
    STYLE_SPARSE,
    STYLE_STACKED,
    STYLE_EMPTY
  } grid_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ROW_W-1:0]     in_row_solid_mask;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 out_strobe;
  logic                 out_rect_valid;
  logic [POS_W-1:0]     out_rect_x;
  logic [POS_W-1:0]     out_rect_y;
  logic [EXT_W-1:0]     out_rect_width;
  logic [EXT_W-1:0]     out_rect_height;
  logic                 out_last_rect;
  int                   fail_count;
  int                   pending;
  int                   quiet_cycles = 0;
  bit                   gaps_on;

  greedy_solid_rect_merge_top #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_row_solid_mask (in_row_solid_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_rect_valid    (out_rect_valid),
    .out_rect_x        (out_rect_x),
    .out_rect_y        (out_rect_y),
    .out_rect_width    (out_rect_width),
    .out_rect_height   (out_rect_height),
    .out_last_rect     (out_last_rect)
  );

  greedy_solid_rect_merge_checker #(
    .GRID_SIDE(GRID_SIDE)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_row_solid_mask (in_row_solid_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_rect_valid    (out_rect_valid),
    .out_rect_x        (out_rect_x),
    .out_rect_y        (out_rect_y),
    .out_rect_width    (out_rect_width),
    .out_rect_height   (out_rect_height),
    .out_last_rect     (out_last_rect),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One row transfer, after an optional random gap
  task automatic send_row(input logic [ROW_W-1:0] mask);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_row_solid_mask <= mask;
    do @(posedge clk); while (busy);
  endtask

  // Alternate two masks down the grid
  task automatic send_pattern(input logic [ROW_W-1:0] even_row, input logic [ROW_W-1:0] odd_row);
    for (int y = 0; y < GRID_SIDE; y++) send_row((y % 2) ? odd_row : even_row);
  endtask

  function automatic logic [ROW_W-1:0] next_row(input grid_style_t style,
                                                input logic [ROW_W-1:0] prev);
    case (style)
      STYLE_DENSE:   return ROW_W'($urandom | $urandom);
      STYLE_SPARSE:  return ROW_W'($urandom & $urandom);
      STYLE_STACKED: return ($urandom_range(0, 2) != 0) ? prev : ROW_W'($urandom);
      STYLE_EMPTY:   return '0;
      default:       return ROW_W'($urandom);
    endcase
  endfunction

  // A grid of random rows; about a quarter of grids run without gaps
  task automatic send_grid();
    grid_style_t      style;
    logic [ROW_W-1:0] row;
    style   = ($urandom_range(0, 9) == 0) ? STYLE_EMPTY
                                          : grid_style_t'($urandom_range(0, 3));
    gaps_on = ($urandom_range(0, 3) != 0);
    row     = ROW_W'($urandom);
    for (int y = 0; y < GRID_SIDE; y++) begin
      row = next_row(style, row);
      send_row(row);
    end
  endtask

  // Hold off until every rectangle is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back; optionally poke the unused index
  task automatic set_regs(input logic [BP_W-1:0] px, input logic [CFG_W-1:0] ox,
                          input logic [CFG_W-1:0] oy, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_PIXELS;
    cfg_wdata <= {(CFG_W-BP_W)'($urandom), px};
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_X;
    cfg_wdata <= ox;
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_Y;
    cfg_wdata <= oy;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_IDX_SPARE;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_row_solid_mask = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_BLOCK_PIXELS;
    cfg_wdata         = '0;
    gaps_on           = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed grids at reset register values
    send_pattern('0, '0);
    send_pattern('1, '1);
    send_pattern(8'h55, 8'hAA);

    // Random grids under a sequence of register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0:       set_regs(8'd255, ORIGIN_TOP, ORIGIN_TOP, 1'b1);
        1:       set_regs(8'd1, '0, '0, 1'b0);
        2:       set_regs(8'd0, CFG_W'($urandom), CFG_W'($urandom), 1'b1);
        default: set_regs(BP_W'($urandom_range(1, 255)), CFG_W'($urandom),
                          CFG_W'($urandom), 1'($urandom_range(0, 1)));
      endcase
      // keep the maximum rectangle count under extreme settings too
      if (p == 0) send_pattern(8'hAA, 8'h55);
      for (int g = 0; g < GRIDS_PER_PHASE; g++) send_grid();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
